// ===== rtl/core/slm_pkg.sv =====
`default_nettype none
package slm_pkg;

  localparam int unsigned ValueW = 32;

  // request codes on the input channel
  localparam logic [1:0] REQ_APPEND_A = 2'd0;
  localparam logic [1:0] REQ_APPEND_B = 2'd1;
  localparam logic [1:0] REQ_MERGE    = 2'd2;

  // operations carried from the front queue to the back engine
  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_MERGE    = 2'd2
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  // handshake group between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/slm_front.sv =====
`default_nettype none
module slm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    in_req_type_i,
  input  wire logic signed [slm_pkg::ValueW-1:0] in_value_i,
  output slm_pkg::cmd_chan_t                 cmd_o,
  input  wire logic                          cmd_ready_i
);
  import slm_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       in_fire;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;

  // classify the request; drop the unused code
  always_comb begin
    keep       = 1'b1;
    new_cmd.op = OP_APPEND_A;
    new_cmd.value = in_value_i;
    unique case (in_req_type_i)
      REQ_APPEND_A: new_cmd.op = OP_APPEND_A;
      REQ_APPEND_B: new_cmd.op = OP_APPEND_B;
      REQ_MERGE:    new_cmd.op = OP_MERGE;
      default:      keep = 1'b0;
    endcase
  end

  assign in_stall_o = (fill_q == 2'd2);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign push       = in_fire && keep;
  assign pop        = cmd_o.valid && cmd_ready_i;

  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.cmd   = q_mem[rd_ptr_q];

  // advance queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/slm_back.sv =====
`default_nettype none
module slm_back #(
  parameter int unsigned SEQ_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire slm_pkg::cmd_chan_t            cmd_i,
  output logic                               cmd_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [slm_pkg::ValueW-1:0]  out_merged_value_o,
  output logic                               out_from_b_o,
  output logic                               out_both_empty_o,
  output logic                               out_last_o
);
  import slm_pkg::*;

  localparam int unsigned CntW = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned IdxW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam logic [CntW-1:0] Full = CntW'(SEQ_DEPTH);
  localparam logic [CntW-1:0] One  = CntW'(1);

  logic signed [ValueW-1:0] mem_a [SEQ_DEPTH];
  logic signed [ValueW-1:0] mem_b [SEQ_DEPTH];
  logic signed [ValueW-1:0] rd_a_q, rd_b_q;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CntW-1:0] ia_q, ia_d, ib_q, ib_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] out_value_q, out_value_d;
  logic                     out_fb_q, out_fb_d;
  logic                     out_empty_q, out_empty_d;
  logic                     out_last_q, out_last_d;
  logic                     emit;

  logic out_free;
  logic cmd_fire;
  logic wr_a, wr_b;
  logic take_a;
  logic done;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && ((cmd_i.cmd.op != OP_MERGE) || out_free);
  assign cmd_fire    = cmd_i.valid && cmd_ready_o;
  assign wr_a = cmd_fire && (cmd_i.cmd.op == OP_APPEND_A) && (cnt_a_q < Full);
  assign wr_b = cmd_fire && (cmd_i.cmd.op == OP_APPEND_B) && (cnt_b_q < Full);

  // pick the smaller head; A wins ties
  assign take_a = (ia_q != cnt_a_q) && ((ib_q == cnt_b_q) || (rd_a_q <= rd_b_q));
  assign done   = take_a ? ((ia_q + One == cnt_a_q) && (ib_q == cnt_b_q))
                         : ((ib_q + One == cnt_b_q) && (ia_q == cnt_a_q));

  // sequence appends and merge steps
  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    emit        = 1'b0;
    out_value_d = out_value_q;
    out_fb_d    = out_fb_q;
    out_empty_d = out_empty_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd_i.cmd.op)
            OP_APPEND_A: if (wr_a) cnt_a_d = cnt_a_q + One;
            OP_APPEND_B: if (wr_b) cnt_b_d = cnt_b_q + One;
            OP_MERGE: begin
              ia_d = '0;
              ib_d = '0;
              if (cnt_a_q == '0 && cnt_b_q == '0) begin
                emit        = 1'b1;
                out_value_d = '0;
                out_fb_d    = 1'b0;
                out_empty_d = 1'b1;
                out_last_d  = 1'b1;
              end else begin
                state_d = ST_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          emit        = 1'b1;
          out_empty_d = 1'b0;
          out_last_d  = done;
          out_fb_d    = !take_a;
          out_value_d = take_a ? rd_a_q : rd_b_q;
          if (take_a) begin
            ia_d = ia_q + One;
          end else begin
            ib_d = ib_q + One;
          end
          if (done) begin
            state_d = ST_IDLE;
            cnt_a_d = '0;
            cnt_b_d = '0;
            ia_d    = '0;
            ib_d    = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold result payload
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_fb_q    <= out_fb_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
  end

  // sequence stores; read data tracks the next head index
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[IdxW-1:0]] <= cmd_i.cmd.value;
    end
    rd_a_q <= mem_a[ia_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[cnt_b_q[IdxW-1:0]] <= cmd_i.cmd.value;
    end
    rd_b_q <= mem_b[ib_d[IdxW-1:0]];
  end

  assign out_valid_o        = out_valid_q;
  assign out_merged_value_o = out_value_q;
  assign out_from_b_o       = out_fb_q;
  assign out_both_empty_o   = out_empty_q;
  assign out_last_o         = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_list_merge_unit.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_req_type_i, in_value_i
// out      output     out_valid_o/out_stall_i out_merged_value_o, out_from_b_o,
//                                            out_both_empty_o, out_last_o
//
// Appends complete in the back engine's idle state; a two-entry command queue
// lets the input take up to two more transfers while a merge runs. If both are
// empty, merges emit one result; else a load state primes the registered store
// reads, then count_a + count_b results follow at one per cycle when unstalled.
// Reset clears both counts and the queue; the stores are not cleared.
// An output stall holds the result register and freezes the merge step.
`default_nettype none
module sorted_list_merge_unit #(
  parameter int unsigned SEQ_DEPTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        in_req_type_i,
  input  wire logic signed [slm_pkg::ValueW-1:0] in_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [slm_pkg::ValueW-1:0]      out_merged_value_o,
  output logic                                   out_from_b_o,
  output logic                                   out_both_empty_o,
  output logic                                   out_last_o
);
  import slm_pkg::*;

  cmd_chan_t cmd;
  logic      cmd_ready;

  slm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .in_value_i    (in_value_i),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  slm_back #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cmd_ready_o        (cmd_ready),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_merged_value_o (out_merged_value_o),
    .out_from_b_o       (out_from_b_o),
    .out_both_empty_o   (out_both_empty_o),
    .out_last_o         (out_last_o)
  );

`ifndef NO_ASSERTIONS
  // empty merge gives a single zero result
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_both_empty_o |->
      out_last_o && !out_from_b_o && (out_merged_value_o == '0))
    else $error("empty merge result malformed");

  // a merge run streams without gaps while the output drains
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=> out_valid_o)
    else $error("merge run dropped a cycle");

  // queue head holds until the back engine takes it
  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.valid && !cmd_ready |=> cmd.valid && $stable(cmd.cmd))
    else $error("queued command changed before transfer");
`endif

endmodule
`default_nettype wire
